@@ src/php_pkg.sv @@
// Package for the PES header parser: section codes, result record type,
// stream id constants and the small decode helpers.
// No dependencies.
package php_pkg;

  typedef enum logic [3:0] {
    SEC_IDLE, SEC_FIXED, SEC_PTS, SEC_DTS, SEC_ESCR, SEC_RATE, SEC_TRICK, SEC_COPY,
    SEC_CRC, SEC_EXTF, SEC_PRIV, SEC_PACKLEN, SEC_PACKSKIP, SEC_SEQ, SEC_PSTD, SEC_STUFF
  } sec_t;

  localparam logic [7:0] SID_PROG_MAP  = 8'hBC;
  localparam logic [7:0] SID_PADDING   = 8'hBE;
  localparam logic [7:0] SID_PRIVATE2  = 8'hBF;
  localparam logic [7:0] SID_ECM       = 8'hF0;
  localparam logic [7:0] SID_EMM       = 8'hF1;
  localparam logic [7:0] SID_PROG_DIR  = 8'hFF;
  localparam logic [7:0] SID_DSMCC     = 8'hF2;
  localparam logic [7:0] SID_H222_E    = 8'hF8;
  localparam logic [7:0] PRIV_SKIP     = 8'd16;

  typedef struct packed {
    logic [7:0]  sid;
    logic [15:0] len;
    logic [15:0] flags;
    logic [32:0] pts;
    logic [32:0] dts;
    logic [41:0] escr;
    logic [21:0] rate;
    logic [12:0] trick;
    logic [6:0]  copy;
    logic [15:0] crc;
    logic [27:0] ext;
    logic [8:0]  ofs;
  } rec_t;

  // Whether a section is present, given the low flag byte and the extension flags.
  function automatic logic sec_present(input logic [3:0] s, input logic [7:0] f,
                                       input logic [7:0] e);
    logic r;
    r = 1'b0;
    unique case (sec_t'(s))
      SEC_PTS:     r = f[7];
      SEC_DTS:     r = (f[7:6] == 2'b11);
      SEC_ESCR:    r = f[5];
      SEC_RATE:    r = f[4];
      SEC_TRICK:   r = f[3];
      SEC_COPY:    r = f[2];
      SEC_CRC:     r = f[1];
      SEC_EXTF:    r = f[0];
      SEC_PRIV:    r = e[7];
      SEC_PACKLEN: r = e[6];
      SEC_SEQ:     r = e[5];
      SEC_PSTD:    r = e[4];
      SEC_STUFF:   r = 1'b1;
      default:     r = 1'b0;
    endcase
    return r;
  endfunction

  // First present section after the given one; stuffing when none is left.
  function automatic sec_t next_sec(input sec_t from, input logic [7:0] f,
                                    input logic [7:0] e);
    sec_t r;
    r = SEC_STUFF;
    for (int i = 14; i >= 1; i--) begin
      if (i > int'(from) && sec_present(4'(i), f, e)) begin
        r = sec_t'(4'(i));
      end
    end
    return r;
  endfunction

  function automatic logic [32:0] stamp33(input logic [47:0] a);
    return {a[35:33], a[31:17], a[15:1]};
  endfunction

  function automatic logic [12:0] trick_decode(input logic [7:0] b);
    logic [12:0] v;
    v = {b[7:5], 10'd0};
    case (b[7:5])
      3'd0, 3'd3: v[9:5] = {b[4:3], b[2], b[1:0]};
      3'd1, 3'd4: v[4:0] = b[4:0];
      3'd2:       v[9:8] = b[4:3];
      default:    v = {b[7:5], 10'd0};
    endcase
    return v;
  endfunction

endpackage

@@ src/php_if.sv @@
// Stream channels of the PES header parser: input bytes and result records.
// No dependencies.
interface php_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       packet_start;
  modport source (output valid, output data_byte, output packet_start, input ready);
  modport sink (input valid, input data_byte, input packet_start, output ready);
endinterface

interface php_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  stream_ident;
  logic [15:0] packet_length;
  logic [15:0] header_flags;
  logic [32:0] pts_value;
  logic [32:0] dts_value;
  logic [41:0] escr_value;
  logic [21:0] es_rate_value;
  logic [12:0] trick_info;
  logic [6:0]  copy_info;
  logic [15:0] previous_crc;
  logic [27:0] extension_info;
  logic [8:0]  payload_offset;
  modport source (output valid, output stream_ident, output packet_length,
                  output header_flags, output pts_value, output dts_value,
                  output escr_value, output es_rate_value, output trick_info,
                  output copy_info, output previous_crc, output extension_info,
                  output payload_offset, input ready);
  modport sink (input valid, input stream_ident, input packet_length,
                input header_flags, input pts_value, input dts_value,
                input escr_value, input es_rate_value, input trick_info,
                input copy_info, input previous_crc, input extension_info,
                input payload_offset, output ready);
endinterface

@@ src/php_parser.sv @@
// Byte-level parse state machine: updates the header record per accepted word.
// Depends on php_pkg.
module php_parser (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          take,
  input  logic [7:0]    din,
  input  logic          start,
  output logic          res_vld,
  output php_pkg::rec_t res_rec
);
  import php_pkg::*;

  logic [8:0]  bi_r, bi_nxt;
  logic [7:0]  hl_r, hl_nxt;
  sec_t        sec_r, sec_nxt;
  logic [2:0]  sb_r, sb_nxt;
  logic [7:0]  skip_r, skip_nxt;
  logic [47:0] acc_r, acc_nxt;
  rec_t        rec_r, rec_nxt;
  logic [7:0]  ext_r, ext_nxt;
  logic        emit, adv;
  sec_t        adv_from;
  logic [47:0] a;
  logic [2:0]  sbi;

  assign a   = {acc_r[39:0], din};
  assign sbi = sb_r + 3'd1;

  always_comb begin
    bi_nxt   = bi_r;
    hl_nxt   = hl_r;
    sec_nxt  = sec_r;
    sb_nxt   = sb_r;
    skip_nxt = skip_r;
    acc_nxt  = acc_r;
    rec_nxt  = rec_r;
    ext_nxt  = ext_r;
    emit     = 1'b0;
    adv      = 1'b0;
    adv_from = sec_r;
    if (take) begin
      if (start) begin
        bi_nxt   = '0;
        hl_nxt   = '0;
        sec_nxt  = SEC_FIXED;
        sb_nxt   = '0;
        skip_nxt = '0;
        acc_nxt  = '0;
        rec_nxt  = '0;
        ext_nxt  = '0;
      end else if (sec_r != SEC_IDLE) begin
        bi_nxt = bi_r + 9'd1;
        if (sec_r == SEC_FIXED) begin
          case (bi_nxt)
            9'd3: rec_nxt.sid = din;
            9'd4: rec_nxt.len = {din, 8'd0};
            9'd5: begin
              rec_nxt.len[7:0] = din;
              if (rec_r.sid == SID_PROG_MAP || rec_r.sid == SID_PADDING ||
                  rec_r.sid == SID_PRIVATE2 || rec_r.sid == SID_ECM ||
                  rec_r.sid == SID_EMM || rec_r.sid == SID_PROG_DIR ||
                  rec_r.sid == SID_DSMCC || rec_r.sid == SID_H222_E) begin
                rec_nxt.ofs = (rec_r.sid == SID_PADDING) ? 9'd0 : 9'd6;
                emit = 1'b1;
              end
            end
            9'd6: rec_nxt.flags = {din, 8'd0};
            9'd7: rec_nxt.flags[7:0] = din;
            9'd8: begin
              hl_nxt      = din;
              rec_nxt.ofs = 9'd9 + {1'b0, din};
              if (din == 8'd0) emit = 1'b1;
              else adv = 1'b1;
            end
            default: ;
          endcase
        end else begin
          acc_nxt = a;
          sb_nxt  = sbi;
          case (sec_r)
            SEC_PTS: if (sbi == 3'd5) begin
              rec_nxt.pts = stamp33(a);
              if (rec_r.flags[7:6] != 2'b11) rec_nxt.dts = stamp33(a);
              adv = 1'b1;
            end
            SEC_DTS: if (sbi == 3'd5) begin
              rec_nxt.dts = stamp33(a);
              adv = 1'b1;
            end
            SEC_ESCR: if (sbi == 3'd6) begin
              rec_nxt.escr = {a[45:43], a[41:40], a[39:27], a[25:11], a[9:8], a[7:1]};
              adv = 1'b1;
            end
            SEC_RATE: if (sbi == 3'd3) begin
              rec_nxt.rate = a[22:1];
              adv = 1'b1;
            end
            SEC_TRICK: begin
              rec_nxt.trick = trick_decode(din);
              adv = 1'b1;
            end
            SEC_COPY: begin
              rec_nxt.copy = din[6:0];
              adv = 1'b1;
            end
            SEC_CRC: if (sbi == 3'd2) begin
              rec_nxt.crc = a[15:0];
              adv = 1'b1;
            end
            SEC_EXTF: begin
              ext_nxt = din;
              adv = 1'b1;
            end
            SEC_PRIV, SEC_PACKSKIP: begin
              if (skip_r > 8'd1) skip_nxt = skip_r - 8'd1;
              else begin
                skip_nxt = '0;
                adv = 1'b1;
              end
            end
            SEC_PACKLEN: begin
              skip_nxt = din;
              if (din == 8'd0) begin
                adv = 1'b1;
                adv_from = SEC_PACKSKIP;
              end else begin
                sec_nxt = SEC_PACKSKIP;
                sb_nxt  = '0;
              end
            end
            SEC_SEQ: if (sbi == 3'd2) begin
              rec_nxt.ext[27:14] = {a[14:8], a[6], a[5:0]};
              adv = 1'b1;
            end
            SEC_PSTD: if (sbi == 3'd2) begin
              rec_nxt.ext[13:0] = a[13:0];
              adv = 1'b1;
            end
            default: ;
          endcase
          if (bi_nxt == 9'd8 + {1'b0, hl_r}) emit = 1'b1;
        end
      end
    end
    if (adv) begin
      sec_nxt = next_sec(adv_from, rec_nxt.flags[7:0], ext_nxt);
      sb_nxt  = '0;
      acc_nxt = '0;
      if (sec_nxt == SEC_PRIV) skip_nxt = PRIV_SKIP;
    end
    if (emit) sec_nxt = SEC_IDLE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bi_r   <= '0;
      hl_r   <= '0;
      sec_r  <= SEC_IDLE;
      sb_r   <= '0;
      skip_r <= '0;
      acc_r  <= '0;
      rec_r  <= '0;
      ext_r  <= '0;
    end else begin
      bi_r   <= bi_nxt;
      hl_r   <= hl_nxt;
      sec_r  <= sec_nxt;
      sb_r   <= sb_nxt;
      skip_r <= skip_nxt;
      acc_r  <= acc_nxt;
      rec_r  <= rec_nxt;
      ext_r  <= ext_nxt;
    end
  end

  assign res_vld = emit;
  assign res_rec = rec_nxt;
endmodule

@@ src/php_out_buf.sv @@
// Result register with a skid stage, so input words keep flowing under a stall until the skid stage fills.
// Depends on php_pkg.
module php_out_buf (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  php_pkg::rec_t push_rec,
  output logic          can_push,
  output logic          out_vld,
  input  logic          out_rdy,
  output php_pkg::rec_t out_rec
);
  import php_pkg::*;

  logic out_vld_r, skid_vld_r;
  rec_t out_r, skid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (!out_vld_r || out_rdy) begin
      if (skid_vld_r) begin
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end else begin
        out_vld_r <= push;
      end
    end else if (push) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_vld_r || out_rdy) begin
      out_r <= skid_vld_r ? skid_r : push_rec;
    end else if (push) begin
      skid_r <= push_rec;
    end
  end

  assign can_push = !skid_vld_r;
  assign out_vld  = out_vld_r;
  assign out_rec  = out_r;
endmodule

@@ src/pes_header_parser_top.sv @@
// PES header parser, top level: parse state machine and result buffer.
// Depends on php_pkg, php_if, php_parser and php_out_buf.
//
// Takes one PES byte per clock, with packet_start marking the first start-code
// byte, and gives one header record per packet: at byte 5 for streams without an
// optional header, else at the last header byte. Each accepted word is decoded in
// the cycle it arrives; the record then passes through the output register (or the
// skid stage under a stall). The input stays ready every cycle; it drops only when
// a result sits stalled in the output register and a second waits in the skid stage.
module pes_header_parser_top (
  input logic        clk,
  input logic        rst_n,
  php_in_if.sink     in_ch,
  php_out_if.source  out_ch
);
  import php_pkg::*;

  logic take, res_vld, can_push;
  rec_t res_rec, out_rec;

  assign take        = in_ch.valid && in_ch.ready;
  assign in_ch.ready = can_push;

  php_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .din     (in_ch.data_byte),
    .start   (in_ch.packet_start),
    .res_vld (res_vld),
    .res_rec (res_rec)
  );

  php_out_buf u_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_vld),
    .push_rec (res_rec),
    .can_push (can_push),
    .out_vld  (out_ch.valid),
    .out_rdy  (out_ch.ready),
    .out_rec  (out_rec)
  );

  assign out_ch.stream_ident   = out_rec.sid;
  assign out_ch.packet_length  = out_rec.len;
  assign out_ch.header_flags   = out_rec.flags;
  assign out_ch.pts_value      = out_rec.pts;
  assign out_ch.dts_value      = out_rec.dts;
  assign out_ch.escr_value     = out_rec.escr;
  assign out_ch.es_rate_value  = out_rec.rate;
  assign out_ch.trick_info     = out_rec.trick;
  assign out_ch.copy_info      = out_rec.copy;
  assign out_ch.previous_crc   = out_rec.crc;
  assign out_ch.extension_info = out_rec.ext;
  assign out_ch.payload_offset = out_rec.ofs;
endmodule

@@ src/php_checker.sv @@
// Port-level checks for the PES header parser, bound to the top level.
// Depends on pes_header_parser_top.
module php_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_start,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_flags_lo,
  input logic [32:0] out_pts,
  input logic [32:0] out_dts
);
  logic in_take;
  assign in_take = in_valid && in_ready;

  // A result waiting for the sink is not withdrawn.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped while stalled");

  // A fresh result always follows an accepted word.
  a_rose_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_take)) else $error("result without input");

  // The first byte of a packet never completes a header.
  a_start_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_take && in_start && !out_valid |=> !out_valid) else $error("result on packet start");

  // With only a PTS present, the DTS copies it.
  a_dts_copy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_flags_lo[7:6] == 2'b10 |-> out_dts == out_pts)
    else $error("DTS differs from PTS");
endmodule

bind pes_header_parser_top php_checker u_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_start     (in_ch.packet_start),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_flags_lo (out_ch.header_flags[7:0]),
  .out_pts      (out_ch.pts_value),
  .out_dts      (out_ch.dts_value)
);
